// ===== hw/rtl/adt_pkg.sv =====
// ----------------------------------------------------------------------------
// adt_pkg
// Types and constants shared by the difficulty target datapath.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int NDIV = 63;
  localparam int PW   = 273;
  localparam int NST  = 2 + NDIV + 8;

  localparam logic [2:0] CFG_SPACING = 3'd0;
  localparam logic [2:0] CFG_HALVING = 3'd1;
  localparam logic [2:0] CFG_LIMIT0  = 3'd2;
  localparam logic [2:0] CFG_LIMIT1  = 3'd3;
  localparam logic [2:0] CFG_LIMIT2  = 3'd4;
  localparam logic [2:0] CFG_LIMIT3  = 3'd5;

  localparam logic [47:0] POLY_C1 = 48'd195766423245049;
  localparam logic [29:0] POLY_C2 = 30'd971821376;
  localparam logic [12:0] POLY_C3 = 13'd5127;
  localparam logic [63:0] POLY_RND = 64'd140737488355328;
  localparam logic [63:0] SCHED_MAX = 64'd562949953421312;

  typedef struct packed {
    logic [63:0]        anchor_word3;
    logic [63:0]        anchor_word2;
    logic [63:0]        anchor_word1;
    logic [63:0]        anchor_word0;
    logic signed [47:0] elapsed_time;
    logic [31:0]        height_gap;
  } in_item_t;

  typedef struct packed {
    logic         sign;
    logic [62:0]  dq;
    logic [31:0]  rem;
    logic [31:0]  dvs;
    logic [255:0] anchor;
  } div_t;

endpackage

// ===== hw/rtl/adt_if.sv =====
// ----------------------------------------------------------------------------
// adt_if
// Valid/ready channels for anchor transactions and next-target transactions.
// ----------------------------------------------------------------------------
interface adt_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        anchor_word0;
  logic [63:0]        anchor_word1;
  logic [63:0]        anchor_word2;
  logic [63:0]        anchor_word3;
  logic signed [47:0] elapsed_time;
  logic [31:0]        height_gap;

  modport source (output valid, anchor_word0, anchor_word1, anchor_word2, anchor_word3,
                  elapsed_time, height_gap, input ready);
  modport sink (input valid, anchor_word0, anchor_word1, anchor_word2, anchor_word3,
                elapsed_time, height_gap, output ready);
endinterface

interface adt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_word0;
  logic [63:0] next_word1;
  logic [63:0] next_word2;
  logic [63:0] next_word3;

  modport source (output valid, next_word0, next_word1, next_word2, next_word3,
                  input ready);
  modport sink (input valid, next_word0, next_word1, next_word2, next_word3,
                output ready);
endinterface

// ===== hw/rtl/adt_front.sv =====
// ----------------------------------------------------------------------------
// adt_front
// Schedule product, drift saturation and divider operand setup (two stages).
// ----------------------------------------------------------------------------
module adt_front (
  input  logic             clk,
  input  logic [1:0]       en,
  input  adt_pkg::in_item_t in_item,
  input  logic [31:0]      spacing,
  input  logic [31:0]      halving,
  output adt_pkg::div_t    div_o
);

  localparam logic signed [50:0] DLIM = 51'sd140737488355327;

  logic [255:0]       a_anchor_r;
  logic signed [47:0] a_elapsed_r;
  logic [63:0]        a_sched_r;
  logic [32:0]        gap1;
  logic [64:0]        sched_full;
  logic signed [50:0] diff;
  logic signed [47:0] drift;
  logic [47:0]        neg_drift;
  logic [46:0]        mag;
  adt_pkg::div_t      div_r;

  assign gap1       = {1'b0, in_item.height_gap} + 33'd1;
  assign sched_full = 65'(spacing) * 65'(gap1);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_anchor_r  <= {in_item.anchor_word3, in_item.anchor_word2,
                      in_item.anchor_word1, in_item.anchor_word0};
      a_elapsed_r <= in_item.elapsed_time;
      a_sched_r   <= sched_full[63:0];
    end
  end

  always_comb begin
    diff = $signed({{3{a_elapsed_r[47]}}, a_elapsed_r}) - $signed({1'b0, a_sched_r[49:0]});
    if (a_sched_r > adt_pkg::SCHED_MAX) begin
      drift = -DLIM[47:0];
    end else if (diff > DLIM) begin
      drift = DLIM[47:0];
    end else if (diff < -DLIM) begin
      drift = -DLIM[47:0];
    end else begin
      drift = diff[47:0];
    end
    neg_drift = -drift;
    mag = drift[47] ? neg_drift[46:0] : drift[46:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_r.sign   <= drift[47];
      div_r.dq     <= {mag, 16'd0};
      div_r.rem    <= 32'd0;
      div_r.dvs    <= (halving == 32'd0) ? 32'd1 : halving;
      div_r.anchor <= a_anchor_r;
    end
  end

  assign div_o = div_r;

endmodule

// ===== hw/rtl/adt_div_cell.sv =====
// ----------------------------------------------------------------------------
// adt_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module adt_div_cell (
  input  logic          clk,
  input  logic          en,
  input  adt_pkg::div_t div_i,
  output adt_pkg::div_t div_o
);

  logic [32:0]   trial;
  logic          ge;
  logic [32:0]   diff;
  adt_pkg::div_t div_nxt;
  adt_pkg::div_t div_r;

  always_comb begin
    trial   = {div_i.rem, div_i.dq[62]};
    ge      = trial >= {1'b0, div_i.dvs};
    diff    = trial - {1'b0, div_i.dvs};
    div_nxt = div_i;
    div_nxt.rem = ge ? diff[31:0] : trial[31:0];
    div_nxt.dq  = {div_i.dq[61:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

// ===== hw/rtl/adt_back.sv =====
// ----------------------------------------------------------------------------
// adt_back
// Exponent split, cubic 2^frac factor, 256x17 product, shift and clamp.
// ----------------------------------------------------------------------------
module adt_back (
  input  logic          clk,
  input  logic [7:0]    en,
  input  adt_pkg::div_t div_i,
  input  logic [255:0]  limit,
  output logic [255:0]  result
);

  localparam int PW = adt_pkg::PW;

  logic signed [63:0] c_exp_r;
  logic [255:0]       c_anchor_r;
  logic [15:0]        d_f_r;
  logic [31:0]        d_f2_r;
  logic [63:0]        d_t1_r;
  logic signed [49:0] d_s_r;
  logic [255:0]       d_anchor_r;
  logic [63:0]        e_t1_r;
  logic [63:0]        e_t2_r;
  logic [47:0]        e_f3_r;
  logic signed [49:0] e_s_r;
  logic [255:0]       e_anchor_r;
  logic [16:0]        f_factor_r;
  logic signed [49:0] f_s_r;
  logic [255:0]       f_anchor_r;
  logic [48:0]        g_p_r [8];
  logic signed [49:0] g_s_r;
  logic [PW-1:0]      h_p_r;
  logic signed [49:0] h_s_r;
  logic [PW-1:0]      i_val_r;
  logic               i_lim_r;
  logic [255:0]       j_res_r;

  logic [63:0]        exp_nxt;
  logic signed [63:0] exp_sh;
  logic [63:0]        t3;
  logic [63:0]        sum;
  logic [PW-1:0]      lo_v;
  logic [PW-1:0]      hi_v;
  logic               nonpos;
  logic [49:0]        rsh;
  logic [PW-1:0]      rv;
  logic [PW-1:0]      lv;
  logic [7:0]         sh;
  logic [8:0]         back_sh;
  logic               ovf;
  logic               lim_nxt;
  logic [PW-1:0]      val_nxt;
  logic [255:0]       res_nxt;

  assign exp_nxt = div_i.sign ? -{1'b0, div_i.dq} : {1'b0, div_i.dq};
  assign exp_sh  = c_exp_r >>> 16;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_exp_r    <= exp_nxt;
      c_anchor_r <= div_i.anchor;
    end
    if (en[1]) begin
      d_f_r      <= c_exp_r[15:0];
      d_f2_r     <= 32'(c_exp_r[15:0]) * 32'(c_exp_r[15:0]);
      d_t1_r     <= 64'(adt_pkg::POLY_C1) * 64'(c_exp_r[15:0]);
      d_s_r      <= exp_sh[49:0] - 50'sd16;
      d_anchor_r <= c_anchor_r;
    end
    if (en[2]) begin
      e_t1_r     <= d_t1_r;
      e_t2_r     <= 64'(adt_pkg::POLY_C2) * 64'(d_f2_r);
      e_f3_r     <= 48'(d_f2_r) * 48'(d_f_r);
      e_s_r      <= d_s_r;
      e_anchor_r <= d_anchor_r;
    end
    if (en[3]) begin
      f_factor_r <= 17'd65536 + {1'b0, sum[63:48]};
      f_s_r      <= e_s_r;
      f_anchor_r <= e_anchor_r;
    end
    if (en[4]) begin
      for (int i = 0; i < 8; i++) begin
        g_p_r[i] <= 49'(f_anchor_r[32*i +: 32]) * 49'(f_factor_r);
      end
      g_s_r <= f_s_r;
    end
    if (en[5]) begin
      h_p_r <= lo_v + hi_v;
      h_s_r <= g_s_r;
    end
    if (en[6]) begin
      i_val_r <= val_nxt;
      i_lim_r <= lim_nxt;
    end
    if (en[7]) begin
      j_res_r <= res_nxt;
    end
  end

  assign t3  = 64'(adt_pkg::POLY_C3) * 64'(e_f3_r);
  assign sum = e_t1_r + e_t2_r + t3 + adt_pkg::POLY_RND;

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < 8; i++) begin
      lo_v[32*i +: 32]     = g_p_r[i][31:0];
      hi_v[32*i+32 +: 17]  = g_p_r[i][48:32];
    end
  end

  always_comb begin
    nonpos  = h_s_r[49] || (h_s_r == 50'sd0);
    rsh     = -h_s_r;
    rv      = (rsh >= 50'd273) ? '0 : (h_p_r >> rsh[8:0]);
    sh      = h_s_r[7:0];
    lv      = h_p_r << sh;
    back_sh = 9'd256 - {1'b0, sh};
    ovf     = |(h_p_r >> back_sh);
    if (nonpos) begin
      lim_nxt = 1'b0;
      val_nxt = rv;
    end else if (h_s_r[48:9] != 40'd0) begin
      lim_nxt = 1'b1;
      val_nxt = '0;
    end else if (h_s_r[8]) begin
      lim_nxt = (h_p_r != '0);
      val_nxt = '0;
    end else begin
      lim_nxt = ovf;
      val_nxt = lv;
    end
  end

  always_comb begin
    if (i_lim_r) begin
      res_nxt = limit;
    end else if (i_val_r == '0) begin
      res_nxt = 256'd1;
    end else if ((i_val_r[PW-1:256] != '0) || (i_val_r[255:0] > limit)) begin
      res_nxt = limit;
    end else begin
      res_nxt = i_val_r[255:0];
    end
  end

  assign result = j_res_r;

endmodule

// ===== hw/rtl/asert_difficulty_target_unit.sv =====
// ----------------------------------------------------------------------------
// asert_difficulty_target_unit
// Exponential next-target calculator for 256-bit proof-of-work targets.
// ----------------------------------------------------------------------------
// Takes one anchor transaction per cycle when the result side keeps up and
// returns its next target through the 63-cell restoring divider chain (one
// quotient bit per cell) plus six front and factor stages and four product,
// shift and clamp stages. Any stall on the result side holds only the
// stages that are full, so bubbles are squeezed out. Configuration writes
// take effect at once; the limit words are read at the final clamp stage, so
// write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module asert_difficulty_target_unit (
  input  logic        clk,
  input  logic        rst_n,
  adt_in_if.sink      in_chan,
  adt_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int NST  = adt_pkg::NST;
  localparam int NDIV = adt_pkg::NDIV;

  logic [31:0]       spacing_r;
  logic [31:0]       halving_r;
  logic [63:0]       limit_r [4];
  logic [NST-1:0]    vld_r;
  logic [NST-1:0]    en;
  adt_pkg::in_item_t in_item;
  adt_pkg::div_t     div_s [NDIV+1];
  logic [255:0]      result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= 32'd600;
      halving_r <= 32'd172800;
      for (int k = 0; k < 4; k++) begin
        limit_r[k] <= '1;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        adt_pkg::CFG_SPACING: spacing_r  <= cfg_wdata[31:0];
        adt_pkg::CFG_HALVING: halving_r  <= cfg_wdata[31:0];
        adt_pkg::CFG_LIMIT0:  limit_r[0] <= cfg_wdata;
        adt_pkg::CFG_LIMIT1:  limit_r[1] <= cfg_wdata;
        adt_pkg::CFG_LIMIT2:  limit_r[2] <= cfg_wdata;
        adt_pkg::CFG_LIMIT3:  limit_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en[NST-1] = !vld_r[NST-1] || out_chan.ready;
  for (genvar k = 0; k < NST-1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = en[0];

  assign in_item.anchor_word0 = in_chan.anchor_word0;
  assign in_item.anchor_word1 = in_chan.anchor_word1;
  assign in_item.anchor_word2 = in_chan.anchor_word2;
  assign in_item.anchor_word3 = in_chan.anchor_word3;
  assign in_item.elapsed_time = in_chan.elapsed_time;
  assign in_item.height_gap   = in_chan.height_gap;

  adt_front u_front (
    .clk     (clk),
    .en      (en[1:0]),
    .in_item (in_item),
    .spacing (spacing_r),
    .halving (halving_r),
    .div_o   (div_s[0])
  );

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    adt_div_cell u_cell (
      .clk   (clk),
      .en    (en[2+k]),
      .div_i (div_s[k]),
      .div_o (div_s[k+1])
    );
  end

  adt_back u_back (
    .clk    (clk),
    .en     (en[NST-1:NST-8]),
    .div_i  (div_s[NDIV]),
    .limit  ({limit_r[3], limit_r[2], limit_r[1], limit_r[0]}),
    .result (result)
  );

  assign out_chan.valid      = vld_r[NST-1];
  assign out_chan.next_word0 = result[63:0];
  assign out_chan.next_word1 = result[127:64];
  assign out_chan.next_word2 = result[191:128];
  assign out_chan.next_word3 = result[255:192];

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(result)))
    else $error("next-target transaction changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (vld_r[NST-1] && !out_chan.ready))
    else $error("input stalled without a blocked result");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NDIV+1] |-> (div_s[NDIV].rem < div_s[NDIV].dvs))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== bench/asert_difficulty_target_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asert_difficulty_target_unit_tb
// Self-checking bench for the exponential next-target calculator.
// ----------------------------------------------------------------------------
// Anchor transactions go in with random gaps. Each accepted one is turned into
// an expected 256-bit target by a bit-exact predictor: saturated drift, scaled
// exponent, cubic 2^frac factor, 512-bit product, shift and clamp. Targets that
// come out are checked in order, word by word. The run steps through several
// register settings, extremes included, and holds the result side off once for
// a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module asert_difficulty_target_unit_tb;

  localparam longint MAX_DRIFT  = (longint'(1) << 47) - 1;
  localparam int     DRAIN      = 90;
  localparam int     IDLE_LIMIT = 5000;

  class target_scoreboard;
    bit [31:0]  spacing = 600;
    bit [31:0]  halving = 172800;
    bit [255:0] limit   = '1;
    bit [255:0] target_q[$];
    int         errors;

    function bit [255:0] next_target(adt_pkg::in_item_t it);
      longint     elapsed, drift, hl, expo, shifts;
      bit [63:0]  sched, frac, sum;
      bit [31:0]  factor;
      bit [511:0] acc;
      int         blen;
      elapsed = longint'(it.elapsed_time);
      sched = 64'(spacing) * (64'(it.height_gap) + 64'd1);
      if (sched > (64'd1 << 49)) begin
        drift = -MAX_DRIFT;
      end else begin
        drift = elapsed - longint'(sched);
        if (drift > MAX_DRIFT) drift = MAX_DRIFT;
        if (drift < -MAX_DRIFT) drift = -MAX_DRIFT;
      end
      hl = (halving == 0) ? 1 : longint'(halving);
      expo = (drift * 65536) / hl;
      frac = expo & 64'hFFFF;
      shifts = (expo - longint'(frac)) / 65536;
      sum = 64'd195766423245049 * frac + 64'd971821376 * frac * frac
          + 64'd5127 * frac * frac * frac + (64'd1 << 47);
      factor = 32'd65536 + 32'(sum >> 48);
      acc = 512'({it.anchor_word3, it.anchor_word2, it.anchor_word1, it.anchor_word0})
          * 512'(factor);
      shifts = shifts - 16;
      if (shifts <= 0) begin
        if (-shifts >= 512) acc = '0;
        else acc = acc >> (-shifts);
      end else begin
        blen = 0;
        for (int i = 511; i >= 0; i--) begin
          if (acc[i] && blen == 0) blen = i + 1;
        end
        if (shifts >= 512 || longint'(blen) + shifts > 512) return limit;
        acc = acc << shifts;
      end
      if (acc == '0) return 256'd1;
      if (acc > {256'd0, limit}) return limit;
      return acc[255:0];
    endfunction

    function void note_anchor(adt_pkg::in_item_t it);
      target_q.push_back(next_target(it));
    endfunction

    function void check_target(bit [255:0] got);
      bit [255:0] want;
      if (target_q.size() == 0) begin
        $error("unexpected next-target transaction %h", got);
        errors++;
        return;
      end
      want = target_q.pop_front();
      for (int w = 0; w < 4; w++) begin
        if (got[w*64 +: 64] !== want[w*64 +: 64]) begin
          $error("next_word%0d: expected %h, got %h", w, want[w*64 +: 64], got[w*64 +: 64]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  bit          calm;
  bit          hold_req;
  int          idle_cycles;

  adt_in_if  in_chan();
  adt_out_if out_chan();

  target_scoreboard sb = new;

  asert_difficulty_target_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    adt_pkg::in_item_t it;
    if (in_chan.valid && in_chan.ready) begin
      it.anchor_word0 = in_chan.anchor_word0;
      it.anchor_word1 = in_chan.anchor_word1;
      it.anchor_word2 = in_chan.anchor_word2;
      it.anchor_word3 = in_chan.anchor_word3;
      it.elapsed_time = in_chan.elapsed_time;
      it.height_gap   = in_chan.height_gap;
      sb.note_anchor(it);
    end
    if (out_chan.valid && out_chan.ready)
      sb.check_target({out_chan.next_word3, out_chan.next_word2,
                       out_chan.next_word1, out_chan.next_word0});
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && rst_n) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_anchor(adt_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.anchor_word0 <= it.anchor_word0;
    in_chan.anchor_word1 <= it.anchor_word1;
    in_chan.anchor_word2 <= it.anchor_word2;
    in_chan.anchor_word3 <= it.anchor_word3;
    in_chan.elapsed_time <= it.elapsed_time;
    in_chan.height_gap   <= it.height_gap;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      adt_pkg::CFG_SPACING: sb.spacing = data[31:0];
      adt_pkg::CFG_HALVING: sb.halving = data[31:0];
      adt_pkg::CFG_LIMIT0:  sb.limit[63:0] = data;
      adt_pkg::CFG_LIMIT1:  sb.limit[127:64] = data;
      adt_pkg::CFG_LIMIT2:  sb.limit[191:128] = data;
      adt_pkg::CFG_LIMIT3:  sb.limit[255:192] = data;
      default: ;
    endcase
  endtask

  task automatic configure(bit [31:0] sp, bit [31:0] hl, bit [255:0] lim);
    write_reg(adt_pkg::CFG_SPACING, 64'(sp));
    write_reg(adt_pkg::CFG_HALVING, 64'(hl));
    write_reg(adt_pkg::CFG_LIMIT0, lim[63:0]);
    write_reg(adt_pkg::CFG_LIMIT1, lim[127:64]);
    write_reg(adt_pkg::CFG_LIMIT2, lim[191:128]);
    write_reg(adt_pkg::CFG_LIMIT3, lim[255:192]);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.target_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic adt_pkg::in_item_t make(bit [255:0] anchor, longint et, bit [31:0] gap);
    adt_pkg::in_item_t it;
    {it.anchor_word3, it.anchor_word2, it.anchor_word1, it.anchor_word0} = anchor;
    it.elapsed_time = et[47:0];
    it.height_gap   = gap;
    return it;
  endfunction

  function automatic adt_pkg::in_item_t random_anchor();
    bit [255:0] anchor;
    bit [31:0]  gap;
    longint     span, et;
    anchor = {rand64(), rand64(), rand64(), rand64()};
    if ($urandom_range(0, 4) == 0)
      return make(anchor, longint'(rand64()), $urandom);
    anchor = anchor >> $urandom_range(0, 255);
    gap = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
    span = longint'(sb.halving | 32'd1) * $urandom_range(1, 24);
    et = longint'(64'(sb.spacing) * (64'(gap) + 64'd1)) + longint'(rand64()) % span;
    if (et > MAX_DRIFT) et = MAX_DRIFT;
    if (et < -MAX_DRIFT) et = -MAX_DRIFT;
    return make(anchor, et, gap);
  endfunction

  task automatic run_random(int n);
    repeat (n) send_anchor(random_anchor());
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= adt_pkg::CFG_SPACING;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.anchor_word0 <= '0;
    in_chan.anchor_word1 <= '0;
    in_chan.anchor_word2 <= '0;
    in_chan.anchor_word3 <= '0;
    in_chan.elapsed_time <= '0;
    in_chan.height_gap   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, field extremes and shift corners
    hold_req = 1'b1;
    send_anchor(make('0, 0, 0));
    send_anchor(make('1, 0, 0));
    send_anchor(make(256'd1, 0, 0));
    send_anchor(make('1, MAX_DRIFT, 0));
    send_anchor(make('1, -MAX_DRIFT, 0));
    send_anchor(make(256'd1, -MAX_DRIFT, 32'hFFFF_FFFF));
    send_anchor(make('1, MAX_DRIFT, 32'hFFFF_FFFF));
    send_anchor(make(256'h1 << 200, 600, 0));
    send_anchor(make(256'h1 << 200, 600 + 172800, 0));
    send_anchor(make(256'h1 << 200, 600 - 172800, 0));
    send_anchor(make(256'h1 << 250, 600 + 172800 * 10, 0));
    send_anchor(make({4{64'hAAAA_AAAA_AAAA_AAAA}}, 86400, 7));
    send_anchor(make({4{64'h5555_5555_5555_5555}}, -86400, 100));
    send_anchor(make(256'h8000, 1 - (longint'(1) << 47), 1));
    run_random(330);
    drain();

    configure(32'd1, 32'd1, '1);
    send_anchor(make(256'd1, MAX_DRIFT, 0));
    send_anchor(make('1, -MAX_DRIFT, 0));
    send_anchor(make(256'd1, 300, 0));
    send_anchor(make(256'd1, -600, 0));
    run_random(330);
    drain();

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, {rand64(), rand64(), rand64(), rand64()});
    send_anchor(make('1, MAX_DRIFT, 32'hFFFF_FFFF));
    run_random(330);
    drain();

    configure(32'd0, 32'd0, '0);
    send_anchor(make('0, 0, 0));
    send_anchor(make('1, 5, 32'hFFFF_FFFF));
    send_anchor(make(256'd3, -3, 0));
    run_random(330);
    drain();

    configure(32'd600, 32'd3600, (256'd1 << 224) - 1);
    run_random(330);
    drain();

    calm = 1'b1;
    configure($urandom, $urandom_range(1, 100000), '1);
    run_random(340);
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
